>>> rtl/bra_pkg.sv
// shared constants, types and helper functions of the bitmap run allocator
package bra_pkg;

	localparam int WW       = 32;
	localparam int LW       = 5;
	localparam int BITS_DEF = 1024;
	localparam int OP_W     = 2;
	localparam int IDX_W    = 10;
	localparam int LEN_W    = 11;
	localparam int CFG_W    = 11;

	localparam logic [CFG_W-1:0] ACTIVE_RST = 11'd1024;

	typedef logic [WW-1:0] word_t;

	typedef enum logic [OP_W-1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_ALLOC = 2'd2,
		OP_FILL  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_WR_RD,
		ST_WR_MOD,
		ST_SCAN,
		ST_FILL,
		ST_DONE
	} state_t;

	// index of lowest set bit, WW when none
	function automatic logic [LW:0] low_one(input word_t v);
		logic [LW:0] r;
		r = (LW+1)'(WW);
		for (int i = WW - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = (LW+1)'(i);
			end
		end
		return r;
	endfunction

	// bit s set when m[s +: len] are all ones inside the word, len from 1 to WW
	function automatic word_t run_window(input word_t m, input logic [LW:0] len);
		logic [WW:0] p;
		logic [WW:0] acc;
		p   = {1'b0, m};
		acc = '1;
		for (int k = 0; k <= LW; k++) begin
			if (len[k]) begin
				acc = p & (acc >> (1 << k));
			end
			p = p & (p >> (1 << k));
		end
		return acc[WW-1:0];
	endfunction

endpackage

>>> rtl/bra_map_ram.sv
// word-wide bit map memory, one write port and one registered read port
module bra_map_ram #(
	parameter int WORDS = 32,
	parameter int AW    = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  bra_pkg::word_t    wdata,
	input  logic [AW-1:0]     raddr,
	output bra_pkg::word_t    rdata
);

	bra_pkg::word_t mem [WORDS];
	bra_pkg::word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/bra_word_eval.sv
// run search unit: evaluates one map word against the requested run
module bra_word_eval #(
	parameter int CW = 11
) (
	input  bra_pkg::word_t  rd_word,
	input  logic [CW-1:0]   base,
	input  logic [CW-1:0]   size,
	input  logic [CW-1:0]   len,
	input  logic            val,
	input  logic [CW-1:0]   carry_run,
	input  logic [CW-1:0]   carry_start,
	output logic            hit,
	output logic [CW-1:0]   hit_start,
	output logic [CW-1:0]   nxt_run,
	output logic [CW-1:0]   nxt_start
);

	localparam int WW = bra_pkg::WW;
	localparam int LW = bra_pkg::LW;

	logic [CW-1:0]  rem;
	bra_pkg::word_t inb;
	bra_pkg::word_t m;
	bra_pkg::word_t m_rev;
	bra_pkg::word_t wnd;
	logic [LW:0]    lead;
	logic [LW:0]    trail;
	logic [LW:0]    widx;
	logic           all_m;
	logic           a_hit;

	always_comb begin
		rem = (size > base) ? (size - base) : '0;
		inb = (rem >= CW'(WW)) ? '1 : ~(bra_pkg::word_t'('1) << rem[LW-1:0]);
		m   = ~(rd_word ^ {WW{val}}) & inb;
		for (int i = 0; i < WW; i++) begin
			m_rev[i] = ~m[WW-1-i];
		end
		lead  = bra_pkg::low_one(~m);
		trail = bra_pkg::low_one(m_rev);
		all_m = &m;

		if (len == '0) begin
			wnd = m;
		end else if (len <= CW'(WW)) begin
			wnd = bra_pkg::run_window(m, (LW+1)'(len));
		end else begin
			wnd = '0;
		end
		widx = bra_pkg::low_one(wnd);

		// run carried in from earlier words completes here
		a_hit = (carry_run != '0) &&
			(({1'b0, carry_run} + (CW+1)'(lead)) >= {1'b0, len});

		hit       = a_hit || (|wnd);
		hit_start = a_hit ? carry_start : (base + CW'(widx[LW-1:0]));

		if (all_m) begin
			nxt_run   = carry_run + CW'(WW);
			nxt_start = (carry_run != '0) ? carry_start : base;
		end else begin
			nxt_run   = CW'(trail);
			nxt_start = base + CW'(WW) - CW'(trail);
		end
	end

endmodule

>>> rtl/bitmap_run_allocator_core.sv
// top level of the bitmap run allocator: sequencer, registers and output stage
//
// channel   direction  handshake             payload
// in        request    in_valid / in_ready   op, start_index, run_length, value
// out       result     out_valid / out_ready found, first_index, bit_value
// cfg       write      cfg_we                cfg_data (active_bits)
//
// read: address state, data state, then done; range write: a read and a modify-write state per map word touched.
// allocate: scans one 32-bit word per cycle, then a read and a modify-write state per word inverted.
// fill: writes one map word per cycle over the whole map.
// after reset a clearing pass writes zero to every map word before the first request is taken.
// a finished result waits in the output register while the next request is taken.
module bitmap_run_allocator_core #(
	parameter int BITS = bra_pkg::BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bra_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bra_pkg::OP_W-1:0]    op,
	input  logic [bra_pkg::IDX_W-1:0]   start_index,
	input  logic [bra_pkg::LEN_W-1:0]   run_length,
	input  logic                        value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [bra_pkg::IDX_W-1:0]   first_index,
	output logic                        bit_value
);

	localparam int WW    = bra_pkg::WW;
	localparam int LW    = bra_pkg::LW;
	localparam int WORDS = (BITS + WW - 1) / WW;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW    = ($clog2(BITS + 1) > bra_pkg::LEN_W) ? $clog2(BITS + 1)
		: bra_pkg::LEN_W;

	bra_pkg::state_t state_q, state_d;
	bra_pkg::op_t    op_q;

	logic [bra_pkg::CFG_W-1:0] active_q;
	logic [CW-1:0]             size;
	logic [AW-1:0]             last_w;

	logic [bra_pkg::IDX_W-1:0] idx_q;
	logic [CW-1:0]             len_q;
	logic                      val_q;
	logic                      wval_q;
	logic [CW-1:0]             lo_q;
	logic [CW-1:0]             hi_q;
	logic [CW-1:0]             hi_end;
	logic [AW-1:0]             lo_w;
	logic [AW-1:0]             hi_w;
	logic [AW-1:0]             ptr_q;
	logic                      iss_end_q;
	logic                      vld_s1;
	logic [AW-1:0]             w_s1;
	logic [CW-1:0]             carry_run_q;
	logic [CW-1:0]             carry_start_q;

	logic                      found_q;
	logic [CW-1:0]             first_q;
	logic                      bitv_q;

	logic                      out_valid_q;
	logic                      out_found_q;
	logic [bra_pkg::IDX_W-1:0] out_first_q;
	logic                      out_bitv_q;

	logic                      accept;
	logic                      load_out;
	logic                      scan_issue;
	logic [CW-1:0]             in_idx;
	logic [CW-1:0]             in_len;
	logic [CW:0]               in_end;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	bra_pkg::word_t            ram_wdata;
	logic [AW-1:0]             ram_raddr;
	bra_pkg::word_t            ram_rdata;

	logic [LW-1:0]             lo_off;
	logic [LW:0]               hi_off;
	bra_pkg::word_t            wr_mask;

	logic                      ev_hit;
	logic [CW-1:0]             ev_start;
	logic [CW-1:0]             ev_run;
	logic [CW-1:0]             ev_cstart;

	assign size   = (CW'(active_q) < CW'(BITS)) ? CW'(active_q) : CW'(BITS);
	assign last_w = AW'((size - CW'(1)) >> LW);
	assign in_idx = CW'(start_index);
	assign in_len = CW'(run_length);
	assign in_end = {1'b0, in_idx} + {1'b0, in_len};
	assign accept = in_valid && in_ready;
	assign hi_end = hi_q - CW'(1);
	assign lo_w   = AW'(lo_q >> LW);
	assign hi_w   = AW'(hi_end >> LW);

	always_comb begin
		lo_off  = (ptr_q == lo_w) ? lo_q[LW-1:0] : '0;
		hi_off  = (ptr_q == hi_w) ? ({1'b0, hi_end[LW-1:0]} + (LW+1)'(1)) : (LW+1)'(WW);
		wr_mask = (bra_pkg::word_t'('1) << lo_off) &
			((hi_off == (LW+1)'(WW)) ? '1 : ~(bra_pkg::word_t'('1) << hi_off[LW-1:0]));
	end

	bra_map_ram #(
		.WORDS (WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bra_word_eval #(
		.CW (CW)
	) u_eval (
		.rd_word     (ram_rdata),
		.base        (CW'(w_s1) << LW),
		.size        (size),
		.len         (len_q),
		.val         (val_q),
		.carry_run   (carry_run_q),
		.carry_start (carry_start_q),
		.hit         (ev_hit),
		.hit_start   (ev_start),
		.nxt_run     (ev_run),
		.nxt_start   (ev_cstart)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bra_pkg::ST_CLEAR: begin
				if (ptr_q == AW'(WORDS - 1)) begin
					state_d = bra_pkg::ST_IDLE;
				end
			end
			bra_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (bra_pkg::op_t'(op))
						bra_pkg::OP_READ: begin
							state_d = (in_idx < size) ? bra_pkg::ST_RD_ADDR : bra_pkg::ST_DONE;
						end
						bra_pkg::OP_WRITE: begin
							state_d = ((in_idx < size) && (in_len != '0)) ? bra_pkg::ST_WR_RD
								: bra_pkg::ST_DONE;
						end
						bra_pkg::OP_ALLOC: begin
							state_d = ((size != '0) && (in_len <= size)) ? bra_pkg::ST_SCAN
								: bra_pkg::ST_DONE;
						end
						bra_pkg::OP_FILL: begin
							state_d = bra_pkg::ST_FILL;
						end
						default: begin
							state_d = bra_pkg::ST_DONE;
						end
					endcase
				end
			end
			bra_pkg::ST_RD_ADDR: begin
				state_d = bra_pkg::ST_RD_DATA;
			end
			bra_pkg::ST_RD_DATA: begin
				state_d = bra_pkg::ST_DONE;
			end
			bra_pkg::ST_WR_RD: begin
				state_d = bra_pkg::ST_WR_MOD;
			end
			bra_pkg::ST_WR_MOD: begin
				state_d = (ptr_q == hi_w) ? bra_pkg::ST_DONE : bra_pkg::ST_WR_RD;
			end
			bra_pkg::ST_SCAN: begin
				if (vld_s1) begin
					if (ev_hit) begin
						state_d = (len_q == '0) ? bra_pkg::ST_DONE : bra_pkg::ST_WR_RD;
					end else if (w_s1 == last_w) begin
						state_d = bra_pkg::ST_DONE;
					end
				end
			end
			bra_pkg::ST_FILL: begin
				if (ptr_q == AW'(WORDS - 1)) begin
					state_d = bra_pkg::ST_DONE;
				end
			end
			bra_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = bra_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bra_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		load_out   = 1'b0;
		scan_issue = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = ptr_q;
		ram_wdata  = '0;
		ram_raddr  = ptr_q;
		case (state_q)
			bra_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
			end
			bra_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			bra_pkg::ST_RD_ADDR: begin
				ram_raddr = AW'(CW'(idx_q) >> LW);
			end
			bra_pkg::ST_WR_MOD: begin
				ram_we    = 1'b1;
				ram_wdata = (ram_rdata & ~wr_mask) | (wr_mask & {WW{wval_q}});
			end
			bra_pkg::ST_SCAN: begin
				scan_issue = !iss_end_q;
			end
			bra_pkg::ST_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = {WW{wval_q}};
			end
			bra_pkg::ST_DONE: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bra_pkg::ST_CLEAR;
			active_q    <= bra_pkg::ACTIVE_RST;
			ptr_q       <= '0;
			iss_end_q   <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_issue;
			if (cfg_we) begin
				active_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				bra_pkg::ST_CLEAR, bra_pkg::ST_FILL: begin
					ptr_q <= (ptr_q == AW'(WORDS - 1)) ? '0 : (ptr_q + AW'(1));
				end
				bra_pkg::ST_IDLE: begin
					if (accept) begin
						iss_end_q <= 1'b0;
						ptr_q     <= (bra_pkg::op_t'(op) == bra_pkg::OP_WRITE)
							? AW'(in_idx >> LW) : '0;
					end
				end
				bra_pkg::ST_WR_MOD: begin
					ptr_q <= ptr_q + AW'(1);
				end
				bra_pkg::ST_SCAN: begin
					if (vld_s1 && ev_hit) begin
						ptr_q <= AW'(ev_start >> LW);
					end else if (scan_issue) begin
						ptr_q     <= ptr_q + AW'(1);
						iss_end_q <= (ptr_q == last_w);
					end
				end
				default: begin
					ptr_q <= ptr_q;
				end
			endcase
		end
	end

	// request and result registers
	always_ff @(posedge clk) begin
		w_s1 <= ptr_q;
		if (accept) begin
			op_q          <= bra_pkg::op_t'(op);
			idx_q         <= start_index;
			len_q         <= in_len;
			val_q         <= value;
			wval_q        <= (bra_pkg::op_t'(op) == bra_pkg::OP_ALLOC) ? ~value : value;
			lo_q          <= in_idx;
			hi_q          <= (in_end < {1'b0, size}) ? CW'(in_end) : size;
			carry_run_q   <= '0;
			carry_start_q <= '0;
			found_q       <= 1'b0;
			first_q       <= '0;
			bitv_q        <= 1'b0;
		end
		if (state_q == bra_pkg::ST_RD_DATA) begin
			bitv_q <= ram_rdata[idx_q[LW-1:0]];
		end
		if ((state_q == bra_pkg::ST_SCAN) && vld_s1) begin
			if (ev_hit) begin
				found_q <= 1'b1;
				first_q <= ev_start;
				lo_q    <= ev_start;
				hi_q    <= ev_start + len_q;
			end else begin
				carry_run_q   <= ev_run;
				carry_start_q <= ev_cstart;
			end
		end
		if (load_out) begin
			out_found_q <= found_q;
			out_first_q <= bra_pkg::IDX_W'(first_q);
			out_bitv_q  <= bitv_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = out_found_q;
	assign first_index = out_first_q;
	assign bit_value   = out_bitv_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request taken while previous one still in progress");

	a_found_only_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && found_q |-> op_q == bra_pkg::OP_ALLOC)
		else $error("found reported for a non-allocate request");

	a_bit_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && bitv_q |-> op_q == bra_pkg::OP_READ)
		else $error("bit value reported for a non-read request");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bra_pkg::ST_WR_MOD |-> (ptr_q >= lo_w) && (ptr_q <= hi_w))
		else $error("word write outside the requested range");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && (state_q == bra_pkg::ST_SCAN) |-> w_s1 <= last_w)
		else $error("scan evaluated a word past the active size");
`endif

endmodule

>>> dv/tb.sv
// self-checking testbench of the bitmap run allocator core
module tb;

	localparam int MAP_BITS     = bra_pkg::BITS_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_TICKS = 16;

	typedef struct packed {
		bra_pkg::op_t              op;
		logic [bra_pkg::IDX_W-1:0] idx;
		logic [bra_pkg::LEN_W-1:0] len;
		logic                      val;
	} req_t;

	typedef struct packed {
		logic                      found;
		logic [bra_pkg::IDX_W-1:0] first;
		logic                      bitv;
	} res_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_we      = 1'b0;
	logic [bra_pkg::CFG_W-1:0] cfg_data    = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic [bra_pkg::OP_W-1:0]  op          = '0;
	logic [bra_pkg::IDX_W-1:0] start_index = '0;
	logic [bra_pkg::LEN_W-1:0] run_length  = '0;
	logic                      value       = 1'b0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic                      found;
	logic [bra_pkg::IDX_W-1:0] first_index;
	logic                      bit_value;

	req_t              pending_requests[$];
	res_t              expected_results[$];
	req_t              next_req;
	res_t              head_result;
	logic [MAP_BITS-1:0] bitmap_model = '0;
	int                active_model   = 1024;
	int                send_idle_pct  = 0;
	int                recv_stall_pct = 0;
	int                mismatches     = 0;
	int                cycle_count    = 0;

	bitmap_run_allocator_core #(
		.BITS(MAP_BITS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.start_index(start_index),
		.run_length (run_length),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.first_index(first_index),
		.bit_value  (bit_value)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch: %s", msg);
		mismatches++;
	endtask

	// updates the map model and returns the result of one request
	function automatic res_t apply_request(input req_t r);
		res_t res;
		int   size;
		int   run;
		int   s;
		bit   done;
		res  = '0;
		size = (active_model < MAP_BITS) ? active_model : MAP_BITS;
		run  = 0;
		done = 1'b0;
		case (r.op)
			bra_pkg::OP_READ: begin
				if (int'(r.idx) < size) begin
					res.bitv = bitmap_model[r.idx];
				end
			end
			bra_pkg::OP_WRITE: begin
				for (int i = 0; i < int'(r.len) && int'(r.idx) + i < size; i++) begin
					bitmap_model[int'(r.idx) + i] = r.val;
				end
			end
			bra_pkg::OP_ALLOC: begin
				for (int i = 0; i < size && !done; i++) begin
					if (bitmap_model[i] != r.val) begin
						run = 0;
					end else if (r.len == '0) begin
						res.found = 1'b1;
						res.first = bra_pkg::IDX_W'(i);
						done      = 1'b1;
					end else begin
						run++;
						if (run >= int'(r.len)) begin
							s = i + 1 - int'(r.len);
							for (int k = s; k <= i; k++) begin
								bitmap_model[k] = ~r.val;
							end
							res.found = 1'b1;
							res.first = bra_pkg::IDX_W'(s);
							done      = 1'b1;
						end
					end
				end
			end
			bra_pkg::OP_FILL: begin
				bitmap_model = {MAP_BITS{r.val}};
			end
			default: begin
				res = '0;
			end
		endcase
		return res;
	endfunction

	function automatic req_t make_req(input bra_pkg::op_t o, input int i, input int l,
		input bit v);
		req_t r;
		r.op  = o;
		r.idx = bra_pkg::IDX_W'(i);
		r.len = bra_pkg::LEN_W'(l);
		r.val = v;
		return r;
	endfunction

	// mostly short runs inside the active size, now and then the extremes
	function automatic req_t random_request();
		req_t r;
		int   size;
		int   pick;
		int   band;
		size  = (active_model < MAP_BITS) ? active_model : MAP_BITS;
		pick  = $urandom_range(99);
		band  = $urandom_range(9);
		r.val = 1'($urandom_range(1));
		if (size > 0 && $urandom_range(9) < 8) begin
			r.idx = bra_pkg::IDX_W'($urandom_range(size - 1));
		end else begin
			r.idx = bra_pkg::IDX_W'($urandom_range(MAP_BITS - 1));
		end
		if (pick < 25) begin
			r.op  = bra_pkg::OP_READ;
			r.len = bra_pkg::LEN_W'($urandom_range(1024));
		end else if (pick < 57) begin
			r.op = bra_pkg::OP_WRITE;
			if (band < 7) begin
				r.len = bra_pkg::LEN_W'($urandom_range(24));
			end else if (band < 9) begin
				r.len = bra_pkg::LEN_W'($urandom_range(200));
			end else begin
				r.len = bra_pkg::LEN_W'($urandom_range(1024));
			end
		end else if (pick < 94) begin
			r.op = bra_pkg::OP_ALLOC;
			if (band < 7) begin
				r.len = bra_pkg::LEN_W'($urandom_range(12));
			end else if (band < 9) begin
				r.len = bra_pkg::LEN_W'($urandom_range(96));
			end else begin
				case ($urandom_range(2))
					0:       r.len = bra_pkg::LEN_W'(1024);
					1:       r.len = bra_pkg::LEN_W'((size < 1024) ? size + 1 : size);
					default: r.len = bra_pkg::LEN_W'(size);
				endcase
			end
		end else begin
			r.op  = bra_pkg::OP_FILL;
			r.len = bra_pkg::LEN_W'($urandom_range(1024));
		end
		return r;
	endfunction

	// waits until every request is taken and every result has come back
	task automatic wait_drained();
		@(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic start_phase(input int cfg, input int send_pct, input int recv_pct);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= bra_pkg::CFG_W'(cfg);
		@(posedge clk);
		cfg_we         <= 1'b0;
		active_model    = cfg;
		send_idle_pct   = send_pct;
		recv_stall_pct  = recv_pct;
	endtask

	task automatic add_random(input int n);
		repeat (n) pending_requests.push_back(random_request());
	endtask

	task automatic add_req(input bra_pkg::op_t o, input int i, input int l, input bit v);
		pending_requests.push_back(make_req(o, i, l, v));
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(apply_request(
					make_req(bra_pkg::op_t'(op), int'(start_index), int'(run_length), value)));
			end
			if (!in_valid || in_ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req     = pending_requests.pop_front();
					in_valid    <= 1'b1;
					op          <= next_req.op;
					start_index <= next_req.idx;
					run_length  <= next_req.len;
					value       <= next_req.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					head_result = expected_results.pop_front();
					if (found !== head_result.found) begin
						report_mismatch($sformatf("found %0b want %0b", found, head_result.found));
					end
					if (first_index !== head_result.first) begin
						report_mismatch($sformatf("first_index %0d want %0d",
							first_index, head_result.first));
					end
					if (bit_value !== head_result.bitv) begin
						report_mismatch($sformatf("bit_value %0b want %0b",
							bit_value, head_result.bitv));
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// full size, no idling
		add_req(bra_pkg::OP_READ, 0, 0, 1'b0);
		add_req(bra_pkg::OP_READ, 1023, 1024, 1'b1);
		add_req(bra_pkg::OP_ALLOC, 0, 0, 1'b0);
		add_req(bra_pkg::OP_ALLOC, 0, 1, 1'b0);
		add_req(bra_pkg::OP_ALLOC, 1023, 0, 1'b1);
		add_req(bra_pkg::OP_WRITE, 1020, 1024, 1'b1);
		add_req(bra_pkg::OP_READ, 1023, 0, 1'b0);
		add_req(bra_pkg::OP_WRITE, 1023, 2047, 1'b0);
		add_req(bra_pkg::OP_READ, 1023, 0, 1'b0);
		add_req(bra_pkg::OP_ALLOC, 0, 1024, 1'b0);
		add_req(bra_pkg::OP_FILL, 0, 0, 1'b0);
		add_req(bra_pkg::OP_ALLOC, 0, 1024, 1'b0);
		add_req(bra_pkg::OP_READ, 512, 0, 1'b0);
		add_req(bra_pkg::OP_ALLOC, 0, 1024, 1'b1);
		add_req(bra_pkg::OP_WRITE, 5, 0, 1'b1);
		add_req(bra_pkg::OP_READ, 5, 0, 1'b0);
		add_req(bra_pkg::OP_WRITE, 10, 3, 1'b1);
		add_req(bra_pkg::OP_ALLOC, 0, 3, 1'b1);
		add_req(bra_pkg::OP_ALLOC, 0, 1, 1'b1);
		add_req(bra_pkg::OP_FILL, 0, 2047, 1'b1);
		add_req(bra_pkg::OP_READ, 0, 0, 1'b0);
		add_req(bra_pkg::OP_ALLOC, 0, 0, 1'b0);
		add_req(bra_pkg::OP_FILL, 1023, 0, 1'b0);
		add_random(300);
		wait_drained();

		start_phase(37, 74, 0);
		add_req(bra_pkg::OP_WRITE, 30, 20, 1'b1);
		add_req(bra_pkg::OP_READ, 36, 0, 1'b0);
		add_req(bra_pkg::OP_READ, 37, 0, 1'b0);
		add_req(bra_pkg::OP_ALLOC, 0, 38, 1'b0);
		add_random(250);
		wait_drained();

		// above the map size, clamped
		start_phase(2047, 0, 74);
		add_random(250);
		wait_drained();

		// empty active size
		start_phase(0, 9, 9);
		add_req(bra_pkg::OP_READ, 0, 0, 1'b0);
		add_req(bra_pkg::OP_WRITE, 0, 5, 1'b1);
		add_req(bra_pkg::OP_ALLOC, 0, 0, 1'b0);
		add_req(bra_pkg::OP_ALLOC, 0, 1, 1'b0);
		add_req(bra_pkg::OP_FILL, 0, 0, 1'b1);
		add_random(60);
		wait_drained();

		start_phase(1, 0, 0);
		add_req(bra_pkg::OP_FILL, 0, 0, 1'b0);
		add_req(bra_pkg::OP_ALLOC, 0, 2, 1'b0);
		add_req(bra_pkg::OP_ALLOC, 0, 1, 1'b0);
		add_req(bra_pkg::OP_READ, 0, 0, 1'b0);
		add_random(100);
		wait_drained();

		start_phase(1025, 9, 9);
		add_random(250);
		wait_drained();

		start_phase($urandom_range(1023, 2), 74, 0);
		add_random(250);
		wait_drained();

		start_phase(1024, 0, 74);
		add_random(240);
		wait_drained();

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> bitmap_run_allocator_core.f
rtl/bra_pkg.sv
rtl/bra_map_ram.sv
rtl/bra_word_eval.sv
rtl/bitmap_run_allocator_core.sv
dv/tb.sv
